@@ src/gmd_pkg.sv @@
// ----------------------------------------------------------------------------
// gmd_pkg: shared types and constants for the grid motion detector
// Grid size, field widths, configuration register indexes and unit op codes.
// ----------------------------------------------------------------------------
`default_nettype none

package gmd_pkg;

  localparam int GRID_CELLS  = 10;
  localparam int SAMPLE_BITS = 12;
  localparam int CELL_COUNT  = GRID_CELLS * GRID_CELLS;
  localparam int IDX_BITS    = $clog2(CELL_COUNT);
  localparam int COORD_BITS  = 4;
  localparam int THR_BITS    = 12;
  localparam int CNT_BITS    = 8;
  localparam int TIME_BITS   = 32;
  localparam int CFG_BITS    = 32;
  localparam int CFG_IDX_BITS = 2;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [IDX_BITS-1:0]           cell_idx_t;
  typedef logic [COORD_BITS-1:0]         coord_t;
  typedef logic [TIME_BITS-1:0]          time_t;

  localparam logic [CFG_IDX_BITS-1:0] CFG_DIFF_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_UPDATE_COUNT   = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_IDLE_WINDOW    = 2'd2;

  localparam logic [THR_BITS-1:0]  RST_DIFF_THRESHOLD = 12'd8;
  localparam logic [CNT_BITS-1:0]  RST_UPDATE_COUNT   = 8'd50;
  localparam logic [TIME_BITS-1:0] RST_IDLE_WINDOW    = 32'd30000;

  // shared unit operations
  localparam logic OP_ABS_GT  = 1'b0;  // |a - b| > lim, a and b signed
  localparam logic OP_WRAP_GE = 1'b1;  // (a - b) mod 2^32 >= lim

  typedef struct packed {
    logic  op;
    time_t a;
    time_t b;
    time_t lim;
  } unit_req_t;

endpackage

`default_nettype wire

@@ src/gmd_cmp_unit.sv @@
// ----------------------------------------------------------------------------
// gmd_cmp_unit: shared subtract and compare unit
// Serves both the sample difference test and the idle window test.
// ----------------------------------------------------------------------------
`default_nettype none

module gmd_cmp_unit (
  input  var gmd_pkg::unit_req_t req,
  output logic                   hit
);
  import gmd_pkg::*;

  time_t diff;
  time_t mag;

  always_comb begin
    diff = req.a - req.b;
    mag  = diff[TIME_BITS-1] ? (~diff + 1'b1) : diff;
    case (req.op)
      OP_ABS_GT:  hit = mag > req.lim;
      OP_WRAP_GE: hit = diff >= req.lim;
      default:    hit = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

@@ src/grid_motion_detector.sv @@
// ----------------------------------------------------------------------------
// grid_motion_detector: background-subtraction motion detector
// Per-cell background and current stores with a change flag per cell.
// ----------------------------------------------------------------------------
// Usage:
//   Input transactions carry one cell sample (capture or detect) and move on
//   in_valid high with in_stall low. Each input gives exactly one result
//   transaction on out_valid / out_stall. Configuration registers are written
//   through cfg_wr / cfg_idx / cfg_data while no transaction is in flight.
// Timing:
//   A capture or off-grid detect item goes from idle straight to the done
//   state, a grid detect passes the difference state first, and a detect at
//   frame end also passes the frame-end state. A background refresh walks
//   all CELL_COUNT cells, one cell per cycle through the single read port of
//   the current store. One item is worked on at a time; in_stall stays high
//   until its result is loaded into the output register.
// Reset:
//   rst clears flags, counter, light, idle timer and restores the register
//   defaults. Background contents are undefined until captured.
// Stall:
//   The result is held in the output register while out_stall is high; a
//   new item is taken meanwhile, but its result waits until the slot frees.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_motion_detector (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_wr,
  input  logic [gmd_pkg::CFG_IDX_BITS-1:0]      cfg_idx,
  input  logic [gmd_pkg::CFG_BITS-1:0]          cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  req_type,
  input  logic [gmd_pkg::COORD_BITS-1:0]        cell_row,
  input  logic [gmd_pkg::COORD_BITS-1:0]        cell_col,
  input  logic signed [gmd_pkg::SAMPLE_BITS-1:0] sample,
  input  logic                                  frame_end,
  input  logic [gmd_pkg::TIME_BITS-1:0]         now_ms,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  report_cell,
  output logic [gmd_pkg::COORD_BITS-1:0]        out_row,
  output logic [gmd_pkg::COORD_BITS-1:0]        out_col,
  output logic                                  motion_light,
  output logic [gmd_pkg::CNT_BITS-1:0]          change_count,
  output logic                                  background_refreshed
);
  import gmd_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DIFF   = 3'd1;
  localparam logic [2:0] S_REF    = 3'd2;
  localparam logic [2:0] S_REFEND = 3'd3;
  localparam logic [2:0] S_FEND   = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  localparam logic [COORD_BITS:0] GRID_LIM = (COORD_BITS+1)'(GRID_CELLS);
  localparam cell_idx_t LAST_IDX = IDX_BITS'(CELL_COUNT - 1);

  logic [2:0] state;

  logic [THR_BITS-1:0]  diff_threshold;
  logic [CNT_BITS-1:0]  update_count;
  time_t                idle_window_ms;

  sample_t bg_mem  [CELL_COUNT];
  sample_t cur_mem [CELL_COUNT];
  sample_t bg_rd;
  sample_t cur_rd;
  logic [CELL_COUNT-1:0] flags;

  logic [CNT_BITS-1:0] cnt;
  logic                frame_motion;
  logic                light;
  time_t               idle_start;

  coord_t    r_row;
  coord_t    r_col;
  sample_t   r_smp;
  logic      r_fend;
  time_t     r_now;
  cell_idx_t r_idx;
  logic      r_report;
  logic      r_refreshed;
  logic      r_above;

  cell_idx_t ref_ptr;
  cell_idx_t ref_wptr;
  logic      ref_wr;

  logic      in_acc;
  logic      in_grid;
  cell_idx_t in_idx;
  logic      bg_we;
  cell_idx_t bg_waddr;
  sample_t   bg_wdata;
  logic      cur_we;
  cell_idx_t cur_raddr;
  logic [CNT_BITS:0] cnt_inc;
  logic      out_load;

  unit_req_t unit_req;
  logic      unit_hit;

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign in_grid  = ({1'b0, cell_row} < GRID_LIM) && ({1'b0, cell_col} < GRID_LIM);
  assign in_idx   = IDX_BITS'(cell_row * GRID_CELLS + cell_col);
  assign cnt_inc  = {1'b0, cnt} + 1'b1;
  assign out_load = (state == S_DONE) && (!out_valid || !out_stall);

  always_comb begin
    if (in_acc && !req_type && in_grid) begin
      bg_we    = 1'b1;
      bg_waddr = in_idx;
      bg_wdata = sample;
    end else begin
      bg_we    = ref_wr && flags[ref_wptr];
      bg_waddr = ref_wptr;
      bg_wdata = cur_rd;
    end
    cur_we    = in_acc && req_type && in_grid;
    cur_raddr = ref_ptr;
  end

  always_comb begin
    if (state == S_DIFF) begin
      unit_req.op  = OP_ABS_GT;
      unit_req.a   = {{(TIME_BITS-SAMPLE_BITS){r_smp[SAMPLE_BITS-1]}}, r_smp};
      unit_req.b   = {{(TIME_BITS-SAMPLE_BITS){bg_rd[SAMPLE_BITS-1]}}, bg_rd};
      unit_req.lim = {{(TIME_BITS-THR_BITS){1'b0}}, diff_threshold};
    end else begin
      unit_req.op  = OP_WRAP_GE;
      unit_req.a   = r_now;
      unit_req.b   = idle_start;
      unit_req.lim = idle_window_ms;
    end
  end

  gmd_cmp_unit u_cmp (
    .req (unit_req),
    .hit (unit_hit)
  );

  always_ff @(posedge clk) begin
    if (bg_we) begin
      bg_mem[bg_waddr] <= bg_wdata;
    end
    bg_rd <= bg_mem[in_idx];
  end

  always_ff @(posedge clk) begin
    if (cur_we) begin
      cur_mem[in_idx] <= sample;
    end
    cur_rd <= cur_mem[cur_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      diff_threshold <= RST_DIFF_THRESHOLD;
      update_count   <= RST_UPDATE_COUNT;
      idle_window_ms <= RST_IDLE_WINDOW;
    end else if (cfg_wr) begin
      case (cfg_idx)
        CFG_DIFF_THRESHOLD: diff_threshold <= cfg_data[THR_BITS-1:0];
        CFG_UPDATE_COUNT:   update_count   <= cfg_data[CNT_BITS-1:0];
        CFG_IDLE_WINDOW:    idle_window_ms <= cfg_data[TIME_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      flags        <= '0;
      cnt          <= '0;
      frame_motion <= 1'b0;
      light        <= 1'b0;
      idle_start   <= '0;
      ref_wr       <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            r_row       <= cell_row;
            r_col       <= cell_col;
            r_smp       <= sample;
            r_fend      <= frame_end;
            r_now       <= now_ms;
            r_idx       <= in_idx;
            r_report    <= 1'b0;
            r_refreshed <= 1'b0;
            if (!req_type) begin
              idle_start <= now_ms;
              state      <= S_DONE;
            end else if (in_grid) begin
              state <= S_DIFF;
            end else if (frame_end) begin
              state <= S_FEND;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_DIFF: begin
          r_above <= unit_hit;
          if (unit_hit || flags[r_idx]) begin
            r_report     <= 1'b1;
            frame_motion <= 1'b1;
            light        <= 1'b1;
            if (cnt_inc >= {1'b0, update_count}) begin
              cnt           <= '0;
              r_refreshed   <= 1'b1;
              flags[r_idx]  <= 1'b1;
              ref_ptr       <= '0;
              state         <= S_REF;
            end else begin
              cnt          <= cnt_inc[CNT_BITS-1:0];
              flags[r_idx] <= unit_hit;
              state        <= r_fend ? S_FEND : S_DONE;
            end
          end else begin
            flags[r_idx] <= 1'b0;
            state        <= r_fend ? S_FEND : S_DONE;
          end
        end
        S_REF: begin
          ref_wr   <= 1'b1;
          ref_wptr <= ref_ptr;
          ref_ptr  <= ref_ptr + 1'b1;
          if (ref_ptr == LAST_IDX) begin
            state <= S_REFEND;
          end
        end
        S_REFEND: begin
          ref_wr       <= 1'b0;
          flags[r_idx] <= r_above;
          state        <= r_fend ? S_FEND : S_DONE;
        end
        S_FEND: begin
          if (!frame_motion) begin
            light <= 1'b0;
            if (unit_hit) begin
              cnt        <= '0;
              idle_start <= r_now;
            end
          end
          frame_motion <= 1'b0;
          state        <= S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            report_cell          <= r_report;
            out_row              <= r_row;
            out_col              <= r_col;
            motion_light         <= light;
            change_count         <= cnt;
            background_refreshed <= r_refreshed;
            state                <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // refresh restarts the count
  assert property (@(posedge clk) disable iff (rst)
    out_valid && background_refreshed |-> change_count == '0)
    else $error("refresh result with nonzero count");

  // a reported cell always leaves the light on
  assert property (@(posedge clk) disable iff (rst)
    out_valid && report_cell |-> motion_light)
    else $error("report without motion light");

  // cells outside the grid never report
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (({1'b0, out_row} >= GRID_LIM) || ({1'b0, out_col} >= GRID_LIM))
    |-> !report_cell)
    else $error("report for cell outside grid");

  // one item at a time
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second transaction taken while busy");

  // refresh writes only while walking the cells
  assert property (@(posedge clk) disable iff (rst)
    ref_wr |-> (state == S_REF || state == S_REFEND))
    else $error("refresh write outside refresh sweep");

endmodule

`default_nettype wire
